### sv/tbp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tbp_pkg
// Shared types, reset values and counter update functions for the
// tournament branch predictor.
// ----------------------------------------------------------------------------
package tbp_pkg;

   localparam int unsigned PC_BITS = 12;

   // table reset values
   localparam logic [1:0] CHOOSER_RESET = 2'd3;   // strongly prefer bimodal
   localparam logic [2:0] BIMODAL_RESET = 3'd0;
   localparam logic [1:0] GSHARE_RESET  = 2'd0;

   // controller -> datapath
   typedef struct packed {
      logic clear;    // write reset values at the sweep address
      logic load;     // capture an incoming request word
      logic rd;       // read the three tables
      logic wr;       // write back the tables, history and result
   } tbp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_last;   // sweep address at the last entry
      logic out_free;     // result register can take a word this cycle
   } tbp_status_type;

   // six-state bimodal counter: 0,1,3,4,6,7; unused codes fall to 0
   function automatic logic [2:0] tbp_six_state_next(input logic [2:0] s,
                                                     input logic       t);
      logic [2:0] n;
      case (s)
         3'd0:    n = t ? 3'd1 : 3'd0;
         3'd1:    n = t ? 3'd3 : 3'd0;
         3'd3:    n = t ? 3'd4 : 3'd1;
         3'd4:    n = t ? 3'd6 : 3'd3;
         3'd6:    n = t ? 3'd7 : 3'd3;
         3'd7:    n = t ? 3'd7 : 3'd6;
         default: n = 3'd0;
      endcase
      return n;
   endfunction

   // 2-bit saturating counter
   function automatic logic [1:0] tbp_sat2_next(input logic [1:0] c,
                                                input logic       up);
      logic [1:0] n;
      if (up) begin
         n = (c == 2'd3) ? 2'd3 : c + 2'd1;
      end else begin
         n = (c == 2'd0) ? 2'd0 : c - 2'd1;
      end
      return n;
   endfunction

endpackage
`default_nettype wire

### sv/tbp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tbp_ctrl
// Sequencer: table clearing sweep, then accept / read / write per branch.
// ----------------------------------------------------------------------------
module tbp_ctrl
   import tbp_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  wire tbp_status_type status,
   output tbp_cmd_type         cmd
);

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_READ  = 4'b0100,
      ST_WRITE = 4'b1000
   } tbp_state_type;

   tbp_state_type state_ff;
   tbp_state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            // hold until the result register has room
            if (status.out_free) begin
               cmd.wr   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

### sv/tbp_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tbp_dp
// Datapath: the three counter tables, global history, clearing sweep
// counter and the result register.
// ----------------------------------------------------------------------------
module tbp_dp
   import tbp_pkg::*;
#(
   parameter int unsigned INDEX_BITS   = 12,
   parameter int unsigned HISTORY_BITS = 12
)(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire tbp_cmd_type         cmd,
   output tbp_status_type           status,
   input  wire logic [PC_BITS-1:0]  req_pc_low,
   input  wire logic                req_taken,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_correct,
   output logic                     rsp_bimodal_correct,
   output logic                     rsp_gshare_correct
);

   localparam int unsigned DEPTH = 1 << INDEX_BITS;

   // tables
   logic [1:0] chooser_mem_ff [DEPTH];
   logic [2:0] bimodal_mem_ff [DEPTH];
   logic [1:0] gshare_mem_ff  [DEPTH];

   logic [INDEX_BITS-1:0]   clr_cnt_ff;
   logic [HISTORY_BITS-1:0] hist_ff;
   logic [HISTORY_BITS-1:0] hist_in;
   logic [PC_BITS-1:0]      pc_ff;
   logic                    taken_ff;

   logic [1:0] cc_ff;
   logic [2:0] bc_ff;
   logic [1:0] gc_ff;

   logic rsp_valid_ff;
   logic rsp_correct_ff;
   logic rsp_bimodal_ff;
   logic rsp_gshare_ff;

   logic [INDEX_BITS-1:0] bidx;
   logic [INDEX_BITS-1:0] gidx;
   logic [31:0]           pc_ext;
   logic [31:0]           hist_ext;
   logic [31:0]           gidx_ext;
   logic                  b_ok;
   logic                  g_ok;
   logic                  ok;

   // index formation
   assign pc_ext   = 32'(pc_ff);
   assign hist_ext = 32'(hist_ff);
   assign gidx_ext = pc_ext ^ hist_ext;
   assign bidx     = pc_ext[INDEX_BITS-1:0];
   assign gidx     = gidx_ext[INDEX_BITS-1:0];

   // predictions against outcome
   assign b_ok    = (bc_ff[2] == taken_ff);
   assign g_ok    = (gc_ff[1] == taken_ff);
   assign ok      = cc_ff[1] ? b_ok : g_ok;
   assign hist_in = HISTORY_BITS'({hist_ff, taken_ff});

   assign status.clear_last = &clr_cnt_ff;
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pc_ff    <= req_pc_low;
         taken_ff <= req_taken;
      end
   end

   // clearing sweep and history
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         hist_ff    <= '0;
      end else begin
         if (cmd.clear) begin
            clr_cnt_ff <= clr_cnt_ff + INDEX_BITS'(1);
         end
         if (cmd.wr) begin
            hist_ff <= hist_in;
         end
      end
   end

   // bimodal table
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         bimodal_mem_ff[clr_cnt_ff] <= BIMODAL_RESET;
      end else if (cmd.wr) begin
         bimodal_mem_ff[bidx] <= tbp_six_state_next(bc_ff, taken_ff);
      end
      if (cmd.rd) begin
         bc_ff <= bimodal_mem_ff[bidx];
      end
   end

   // gshare table
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         gshare_mem_ff[clr_cnt_ff] <= GSHARE_RESET;
      end else if (cmd.wr) begin
         gshare_mem_ff[gidx] <= tbp_sat2_next(gc_ff, taken_ff);
      end
      if (cmd.rd) begin
         gc_ff <= gshare_mem_ff[gidx];
      end
   end

   // chooser table: moves only when the components disagree
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         chooser_mem_ff[clr_cnt_ff] <= CHOOSER_RESET;
      end else if (cmd.wr && (b_ok != g_ok)) begin
         chooser_mem_ff[bidx] <= tbp_sat2_next(cc_ff, b_ok);
      end
      if (cmd.rd) begin
         cc_ff <= chooser_mem_ff[bidx];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.wr) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         rsp_correct_ff <= ok;
         rsp_bimodal_ff <= b_ok;
         rsp_gshare_ff  <= g_ok;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_correct         = rsp_correct_ff;
   assign rsp_bimodal_correct = rsp_bimodal_ff;
   assign rsp_gshare_correct  = rsp_gshare_ff;

`ifndef NO_ASSERTIONS
   // a pending result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.wr |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwritten while stalled");

   // newest outcome enters history at bit 0
   a_hist_shift: assert property (@(posedge clock) disable iff (reset)
      cmd.wr |=> (hist_ff[0] == $past(taken_ff)))
      else $error("history not shifted with outcome");

   // chosen result equals one of the component results
   a_choice: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_correct_ff == rsp_bimodal_ff ||
                        rsp_correct_ff == rsp_gshare_ff))
      else $error("chosen result matches no component");

   // no table traffic during the clearing sweep
   a_clear_excl: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> (!cmd.rd && !cmd.wr && !cmd.load))
      else $error("table access during clearing sweep");
`endif

endmodule
`default_nettype wire

### sv/tournament_branch_predictor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tournament_branch_predictor
// Bimodal plus gshare predictor with a per-address chooser, trained on
// resolved branches.
// ----------------------------------------------------------------------------
// Each request word is one resolved branch (low 12 address bits and its
// outcome); each response word says whether the chosen prediction, the
// bimodal prediction and the gshare prediction matched that outcome, as
// seen before the tables are trained on it. After reset the block runs a
// clearing pass over all 2**INDEX_BITS entries of the three tables, with
// req_stall high. After that each branch passes through capture, table
// read and table write-back before the next one is accepted, since each
// table memory has a single read then write per branch. The response
// sits in an output register, so a new request is taken while it waits;
// the write-back cycle holds off only while an undelivered response is
// still being stalled.
// ----------------------------------------------------------------------------
module tournament_branch_predictor
   import tbp_pkg::*;
#(
   parameter int unsigned INDEX_BITS   = 12,
   parameter int unsigned HISTORY_BITS = 12
)(
   input  wire logic                clock,
   input  wire logic                reset,
   // request channel
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [PC_BITS-1:0]  req_pc_low,
   input  wire logic                req_taken,
   // response channel
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_correct,
   output logic                     rsp_bimodal_correct,
   output logic                     rsp_gshare_correct
);

   tbp_cmd_type    cmd;
   tbp_status_type status;

   // sequencer
   tbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // tables, history, result register
   tbp_dp #(
      .INDEX_BITS   (INDEX_BITS),
      .HISTORY_BITS (HISTORY_BITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_pc_low          (req_pc_low),
      .req_taken           (req_taken),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_correct         (rsp_correct),
      .rsp_bimodal_correct (rsp_bimodal_correct),
      .rsp_gshare_correct  (rsp_gshare_correct)
   );

endmodule
`default_nettype wire
